FILE: rtl/core/move_to_front_codec_top_macros.svh
`ifndef MOVE_TO_FRONT_CODEC_TOP_MACROS_SVH
`define MOVE_TO_FRONT_CODEC_TOP_MACROS_SVH

// same-cycle implication
`define MTF_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MTF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/mtf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mtf_pkg;

    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic MODE_IDX = 1'b0;

    typedef enum logic
    {
        MODE_ENC = 1'b0,
        MODE_DEC = 1'b1
    } mtf_mode_t;

    typedef struct packed
    {
        logic valid;
        logic done;
    } mtf_ctl_t;

endpackage

`default_nettype wire

FILE: rtl/core/mtf_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface mtf_sym_if;
    logic       valid;
    logic       ready;
    logic [7:0] symbol;
    logic       first;

    modport source (output valid, output symbol, output first, input ready);
    modport sink (input valid, input symbol, input first, output ready);
endinterface

interface mtf_val_if;
    logic       valid;
    logic       ready;
    logic [7:0] value;

    modport source (output valid, output value, input ready);
    modport sink (input valid, input value, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/mtf_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module mtf_cell #(
    parameter int W        = 8,
    parameter int IDX      = 0,
    parameter bit LAST_CELL = 1'b0
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  logic              front_wr,
    input  logic [W-1:0]      front_val,
    input  mtf_pkg::mtf_mode_t mode,
    input  logic [W-1:0]      key,
    input  mtf_pkg::mtf_ctl_t ctl_i,
    input  logic [W-1:0]      carry_i,
    input  logic [W-1:0]      held_i,
    input  logic [W-1:0]      pos_i,
    output mtf_pkg::mtf_ctl_t ctl_o,
    output logic [W-1:0]      carry_o,
    output logic [W-1:0]      held_o,
    output logic [W-1:0]      pos_o
);

    logic [W-1:0]      entry_reg;
    logic [W-1:0]      entry_next;
    mtf_pkg::mtf_ctl_t ctl_reg;
    mtf_pkg::mtf_ctl_t ctl_next;
    logic [W-1:0]      carry_reg;
    logic [W-1:0]      held_reg;
    logic [W-1:0]      held_next;
    logic [W-1:0]      pos_reg;
    logic [W-1:0]      pos_next;
    logic              stop;

    always_comb
    begin
        if (mode == mtf_pkg::MODE_DEC)
        begin
            stop = (key == W'(IDX));
        end
        else
        begin
            stop = (entry_reg == key) || LAST_CELL;
        end
    end

    always_comb
    begin
        entry_next = entry_reg;
        ctl_next   = ctl_i;
        held_next  = held_i;
        pos_next   = pos_i;
        if (load)
        begin
            entry_next = W'(IDX);
        end
        else if (front_wr)
        begin
            entry_next = front_val;
        end
        else if (ctl_i.valid && !ctl_i.done)
        begin
            // shift the upstream entry in; the stopping cell hands its own entry on
            entry_next = carry_i;
            if (stop)
            begin
                held_next     = entry_reg;
                pos_next      = W'(IDX);
                ctl_next.done = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg <= W'(IDX);
            ctl_reg   <= '0;
        end
        else
        begin
            entry_reg <= entry_next;
            ctl_reg   <= ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        carry_reg <= entry_reg;
        held_reg  <= held_next;
        pos_reg   <= pos_next;
    end

    assign ctl_o   = ctl_reg;
    assign carry_o = carry_reg;
    assign held_o  = held_reg;
    assign pos_o   = pos_reg;

endmodule

`default_nettype wire

FILE: rtl/core/move_to_front_codec_top.sv
// move-to-front coder over an alphabet of ALPHABET symbols
// items: symbol plus first flag, one transfer per item; first reloads the
//   identity list before the item is coded
// results: one value per item, in item order
// apb port: register mode at byte address 0, bit 0 (0 encode, 1 decode);
//   write it only while the block is idle; pready is always high
// the list lives in a row of ALPHABET cells; a token enters cell 0 the cycle
//   after the item transfer and steps one cell per cycle, shifting entries back
//   until it reaches the match (encode) or the addressed position (decode)
// result path: the last cell hands it to a finish register, then to the output
//   register on results; no new item is taken until the token has walked
//   through the whole row of cells
// the next item is taken while a finished result still waits on results;
//   a stalled receiver holds value steady and, once one further result is
//   finished behind it, items.ready stays low
// reset: list returns to identity order, mode to encode, no result pending
`timescale 1ns / 1ps
`default_nettype none

module move_to_front_codec_top #(
    parameter int ALPHABET = 256
) (
    input  logic                          clk,
    input  logic                          rst_n,
    mtf_sym_if.sink                       items,
    mtf_val_if.source                     results,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mtf_pkg::PADDR_W-1:0]   paddr,
    input  logic [mtf_pkg::PDATA_W-1:0]   pwdata,
    output logic [mtf_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);

    localparam int W  = $clog2(ALPHABET);
    localparam int IW = (W > 8) ? W : 8;

    mtf_pkg::mtf_mode_t mode_reg;
    mtf_pkg::mtf_mode_t mode_next;
    logic [W-1:0]       key_reg;
    logic [W-1:0]       key_next;
    logic               start_reg;
    logic               run_reg;
    logic               run_next;
    logic               fin_valid_reg;
    logic               fin_valid_next;
    logic [7:0]         fin_value_reg;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [7:0]         out_value_reg;

    logic               accept;
    logic               cfg_wr;
    logic               move;
    logic               arrive;
    logic [IW-1:0]      sym_w;
    logic [W-1:0]       res_w;

    mtf_pkg::mtf_ctl_t  ctl_w   [0:ALPHABET];
    logic [W-1:0]       carry_w [0:ALPHABET];
    logic [W-1:0]       held_w  [0:ALPHABET];
    logic [W-1:0]       pos_w   [0:ALPHABET];

    assign accept = items.valid && items.ready;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign arrive = ctl_w[ALPHABET].valid;
    assign move   = fin_valid_reg && (!out_valid_reg || results.ready);

    assign items.ready   = !run_reg && (!fin_valid_reg || move);
    assign results.valid = out_valid_reg;
    assign results.value = out_value_reg;

    assign pready = 1'b1;
    assign prdata = (paddr[mtf_pkg::PADDR_W-1] == mtf_pkg::MODE_IDX)
                    ? {{(mtf_pkg::PDATA_W-1){1'b0}}, mode_reg}
                    : '0;

    // clamp out-of-alphabet inputs to the last entry
    assign sym_w    = IW'(items.symbol);
    assign key_next = (sym_w > IW'(ALPHABET - 1)) ? W'(ALPHABET - 1) : W'(sym_w);

    assign ctl_w[0]   = '{valid: start_reg, done: 1'b0};
    assign carry_w[0] = '0;
    assign held_w[0]  = '0;
    assign pos_w[0]   = '0;

    for (genvar i = 0; i < ALPHABET; i++)
    begin : g_cell
        mtf_cell #(
            .W         (W),
            .IDX       (i),
            .LAST_CELL (i == ALPHABET - 1)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .load      (accept && items.first),
            .front_wr  ((i == 0) ? arrive : 1'b0),
            .front_val (held_w[ALPHABET]),
            .mode      (mode_reg),
            .key       (key_reg),
            .ctl_i     (ctl_w[i]),
            .carry_i   (carry_w[i]),
            .held_i    (held_w[i]),
            .pos_i     (pos_w[i]),
            .ctl_o     (ctl_w[i+1]),
            .carry_o   (carry_w[i+1]),
            .held_o    (held_w[i+1]),
            .pos_o     (pos_w[i+1])
        );
    end

    assign res_w = (mode_reg == mtf_pkg::MODE_DEC) ? held_w[ALPHABET] : pos_w[ALPHABET];

    always_comb
    begin
        mode_next = mode_reg;
        if (cfg_wr && (paddr[mtf_pkg::PADDR_W-1] == mtf_pkg::MODE_IDX))
        begin
            mode_next = mtf_pkg::mtf_mode_t'(pwdata[0]);
        end
    end

    always_comb
    begin
        run_next = run_reg;
        if (accept)
        begin
            run_next = 1'b1;
        end
        else if (arrive)
        begin
            run_next = 1'b0;
        end
    end

    always_comb
    begin
        fin_valid_next = fin_valid_reg;
        if (arrive)
        begin
            fin_valid_next = 1'b1;
        end
        else if (move)
        begin
            fin_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (move)
        begin
            out_valid_next = 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= mtf_pkg::MODE_ENC;
            start_reg     <= 1'b0;
            run_reg       <= 1'b0;
            fin_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mode_reg      <= mode_next;
            start_reg     <= accept;
            run_reg       <= run_next;
            fin_valid_reg <= fin_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            key_reg <= key_next;
        end
        if (arrive)
        begin
            fin_value_reg <= 8'(res_w);
        end
        if (move)
        begin
            out_value_reg <= fin_value_reg;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/mtf_checker.sv
`timescale 1ns / 1ps
`default_nettype none

`include "move_to_front_codec_top_macros.svh"

module mtf_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_value
);

    `MTF_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_value), "stalled result changed")
    `MTF_ASSERT_NEXT(a_busy_after_item, in_valid && in_ready, !in_ready, "item taken while coding")
    `MTF_ASSERT_NEXT(a_no_early_result, in_valid && in_ready, ##1 !$rose(out_valid), "result too early")

endmodule

bind move_to_front_codec_top mtf_checker u_mtf_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (items.valid),
    .in_ready  (items.ready),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .out_value (results.value)
);

`default_nettype wire

FILE: verif/move_to_front_codec_top_tb.sv
`timescale 1ns / 1ps

module move_to_front_codec_top_tb;

    localparam int ALPHABET = 256;
    localparam int LATENCY = ALPHABET + 2;
    localparam logic [mtf_pkg::PADDR_W-1:0] MODE_ADDR = {mtf_pkg::MODE_IDX, 2'b00};
    localparam logic [mtf_pkg::PADDR_W-1:0] SPARE_ADDR = {~mtf_pkg::MODE_IDX, 2'b00};
    localparam longint TIMEOUT_CYCLES = 3_000_000;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [mtf_pkg::PADDR_W-1:0] paddr;
    logic [mtf_pkg::PDATA_W-1:0] pwdata;
    logic [mtf_pkg::PDATA_W-1:0] prdata;
    logic pready;

    mtf_sym_if items_if();
    mtf_val_if results_if();

    move_to_front_codec_top #(
        .ALPHABET(ALPHABET)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .items(items_if),
        .results(results_if),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    // predictor state
    int mtf_list [ALPHABET];
    mtf_pkg::mtf_mode_t mtf_mode;
    logic [7:0] mtf_value_q [$];

    int mismatches = 0;
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int rx_hold_left = 0;

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    function automatic void mtf_load_identity();
        for (int i = 0; i < ALPHABET; i++)
            mtf_list[i] = i;
    endfunction

    function automatic logic [7:0] mtf_code(input logic [7:0] sym, input logic frst);
        int key;
        int pos;
        int held;
        logic [7:0] code;
        if (frst)
            mtf_load_identity();
        key = (int'(sym) >= ALPHABET) ? ALPHABET - 1 : int'(sym);
        if (mtf_mode == mtf_pkg::MODE_ENC)
        begin
            pos = 0;
            while (pos < ALPHABET - 1 && mtf_list[pos] != key)
                pos++;
            code = 8'(pos);
        end
        else
        begin
            pos = key;
            code = 8'(mtf_list[pos]);
        end
        // move touched entry to the front
        held = mtf_list[pos];
        for (int i = pos; i > 0; i--)
            mtf_list[i] = mtf_list[i - 1];
        mtf_list[0] = held;
        return code;
    endfunction

    function automatic logic [7:0] pick_symbol();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 45)
            return 8'($urandom_range(0, 7));
        if (roll < 60)
            return 8'(255 - $urandom_range(0, 3));
        return 8'($urandom_range(0, 255));
    endfunction

    // receiver side
    always @(negedge clk)
    begin
        if (rx_hold_left > 0)
        begin
            rx_hold_left--;
            results_if.ready <= 1'b0;
        end
        else
            results_if.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    // result checking
    always @(posedge clk)
    begin
        if (rst_n && results_if.valid && results_if.ready)
        begin
            if (mtf_value_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transfer: value %0d at %0t",
                             results_if.value, $time);
            end
            else if (results_if.value !== mtf_value_q[0])
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("value mismatch: expected %0d, got %0d at %0t",
                             mtf_value_q[0], results_if.value, $time);
                void'(mtf_value_q.pop_front());
            end
            else
                void'(mtf_value_q.pop_front());
        end
    end

    task automatic send_item(input logic [7:0] sym, input logic frst);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            items_if.valid <= 1'b0;
            @(negedge clk);
        end
        items_if.valid <= 1'b1;
        items_if.symbol <= sym;
        items_if.first <= frst;
        @(posedge clk);
        while (!items_if.ready)
            @(posedge clk);
        mtf_value_q.push_back(mtf_code(sym, frst));
        @(negedge clk);
    endtask

    task automatic wait_drained();
        items_if.valid <= 1'b0;
        while (mtf_value_q.size() != 0)
            @(posedge clk);
        repeat (LATENCY) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic apb_write(input logic [mtf_pkg::PADDR_W-1:0] addr,
                             input logic [mtf_pkg::PDATA_W-1:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (addr == MODE_ADDR)
            mtf_mode = mtf_pkg::mtf_mode_t'(data[0]);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge clk);
    endtask

    task automatic set_mode(input logic [mtf_pkg::PADDR_W-1:0] addr,
                            input logic [mtf_pkg::PDATA_W-1:0] data);
        wait_drained();
        apb_write(addr, data);
    endtask

    task automatic test_directed_encode();
        set_mode(MODE_ADDR, 32'(mtf_pkg::MODE_ENC));
        send_item(8'd0, 1'b0);
        send_item(8'd0, 1'b0);
        send_item(8'd255, 1'b0);
        send_item(8'd255, 1'b0);
        send_item(8'd0, 1'b0);
        send_item(8'd128, 1'b1);
        send_item(8'd128, 1'b0);
        send_item(8'd1, 1'b0);
        send_item(8'd254, 1'b0);
        send_item(8'd255, 1'b1);
    endtask

    task automatic test_directed_decode();
        set_mode(MODE_ADDR, 32'(mtf_pkg::MODE_DEC));
        send_item(8'd0, 1'b1);
        send_item(8'd255, 1'b0);
        send_item(8'd255, 1'b0);
        send_item(8'd0, 1'b0);
        send_item(8'd1, 1'b0);
        send_item(8'd128, 1'b0);
        send_item(8'd127, 1'b1);
        send_item(8'd0, 1'b0);
        send_item(8'd255, 1'b1);
        send_item(8'd254, 1'b0);
    endtask

    // writes to an unmapped address are dropped, only bit 0 of mode counts
    task automatic test_register_decoding();
        set_mode(SPARE_ADDR, 32'h0000_0000);
        send_item(8'd3, 1'b0);
        send_item(8'd200, 1'b0);
        set_mode(MODE_ADDR, 32'hFFFF_FFFE);
        send_item(8'd3, 1'b0);
        send_item(8'd200, 1'b0);
        set_mode(SPARE_ADDR, 32'hFFFF_FFFF);
        send_item(8'd7, 1'b1);
    endtask

    task automatic test_random_traffic(input int tx_pct, input int rx_pct, input int count,
                                       input logic [mtf_pkg::PDATA_W-1:0] mode_word);
        set_mode(MODE_ADDR, mode_word);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        for (int i = 0; i < count; i++)
            send_item(pick_symbol(), ($urandom_range(0, 99) < 4));
    endtask

    // receiver holds off long enough for the block to stall its input
    task automatic test_backpressure();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        rx_hold_left = 3 * LATENCY + 200;
        for (int i = 0; i < 6; i++)
            send_item(pick_symbol(), 1'b0);
    endtask

    task automatic test_drain_pause();
        tx_idle_pct = 10;
        rx_idle_pct = 10;
        for (int i = 0; i < 5; i++)
            send_item(pick_symbol(), 1'b0);
        wait_drained();
        for (int i = 0; i < 5; i++)
            send_item(pick_symbol(), 1'b0);
    endtask

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        items_if.valid = 1'b0;
        items_if.symbol = '0;
        items_if.first = 1'b0;
        results_if.ready = 1'b0;
        mtf_load_identity();
        mtf_mode = mtf_pkg::MODE_ENC;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed_encode();
        test_directed_decode();
        test_register_decoding();
        test_random_traffic(23, 87, 290, 32'h0000_0000);
        test_random_traffic(23, 87, 290, 32'hFFFF_FFFF);
        test_random_traffic(87, 23, 290, 32'h0000_0001);
        test_random_traffic(87, 23, 290, 32'hFFFF_FFFE);
        test_random_traffic(0, 0, 290, 32'h0000_0001);
        test_random_traffic(0, 0, 290, 32'h0000_0000);
        test_backpressure();
        test_drain_pause();

        wait_drained();
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        #(TIMEOUT_CYCLES * 8);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
